[src/imu_strike_classifier_defines.svh]
// Assertion macros for the strike classifier.
// Depends on nothing; users must have clk and rst in scope.
// SYNTH selects the empty bodies.
`ifndef IMU_STRIKE_CLASSIFIER_DEFINES_SVH
`define IMU_STRIKE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTH
`define ISC_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ISC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ISC_ASSERT_IMPLY(name, ante, cons)
`define ISC_ASSERT_NEXT(name, ante, cons)
`endif

`endif

[src/isc_pkg.sv]
// Package for the strike classifier: payload structs, register indexes,
// reset values and zone codes. No dependencies.
package isc_pkg;

  localparam int AccelW = 16;
  localparam int TimeW  = 32;
  localparam int CfgW   = 16;
  localparam int VelW   = 7;
  localparam int ZoneW  = 2;
  localparam int NumZones = 4;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_COOLDOWN  = 3'd1,
    REG_DIVISOR   = 3'd2,
    REG_VEL_MIN   = 3'd3,
    REG_VEL_MAX   = 3'd4
  } cfg_reg_t;

  localparam logic [CfgW-1:0] THRESHOLD_RST = 16'd15000;
  localparam logic [CfgW-1:0] COOLDOWN_RST  = 16'd150;
  localparam logic [CfgW-1:0] DIVISOR_RST   = 16'd500;
  localparam logic [VelW-1:0] VEL_MIN_RST   = 7'd20;
  localparam logic [VelW-1:0] VEL_MAX_RST   = 7'd127;

  localparam logic [ZoneW-1:0] ZONE_Z_NEG = 2'd0;
  localparam logic [ZoneW-1:0] ZONE_Z_POS = 2'd1;
  localparam logic [ZoneW-1:0] ZONE_X     = 2'd2;
  localparam logic [ZoneW-1:0] ZONE_Y     = 2'd3;

  typedef struct packed {
    logic signed [AccelW-1:0] accel_x;
    logic signed [AccelW-1:0] accel_y;
    logic signed [AccelW-1:0] accel_z;
    logic [TimeW-1:0]         now_ms;
  } sample_t;

  typedef struct packed {
    logic [ZoneW-1:0] zone;
    logic [VelW-1:0]  strength;
    logic [TimeW-1:0] hit_time_ms;
  } hit_t;

endpackage

[src/imu_strike_classifier.sv]
// Strike classifier: one accelerometer sample in, zero or one hit out.
// A sample runs through squaring and a check; a sample that is reported as
// a hit then runs through square root, divide and finish before hit_valid,
// with the square-root and divide loops giving one bit per cycle.
// A new sample is taken only once the last one is through, and later still
// while a finished hit waits for hit_ready. Sync reset restores register
// defaults and clears all per-zone strike times to zero.
`include "imu_strike_classifier_defines.svh"

module imu_strike_classifier
  import isc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  sample_t            sample,
  output logic               hit_valid,
  input  logic               hit_ready,
  output hit_t               hit,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CHECK, ST_SQRT, ST_DIV, ST_FIN
  } state_t;

  state_t state;
  logic [3:0] cnt;

  logic [CfgW-1:0] threshold, cooldown, divisor;
  logic [VelW-1:0] vel_min, vel_max;

  logic [AccelW:0]   mag_x, mag_y, mag_z;
  logic              z_neg;
  logic [TimeW-1:0]  now_q;
  logic [2*AccelW+1:0] prod;
  logic [31:0]       sum, thr2, sq_n;
  logic [16:0]       rem;
  logic [15:0]       root;
  logic [ZoneW-1:0]  zone_q;
  logic [TimeW-1:0]  last_strike [NumZones];

  logic [AccelW:0]   mul_a;
  logic [18:0]       sub_a, sub_b;
  logic [19:0]       diff;
  logic              take;
  logic [ZoneW-1:0]  zone_next;
  logic [TimeW-1:0]  delta;
  logic [VelW-1:0]   vel_clip, vel;

  assign sample_ready = (state == ST_IDLE);

  // squaring operand
  always_comb begin
    case (cnt[1:0])
      2'd0:    mul_a = mag_x;
      2'd1:    mul_a = mag_y;
      2'd2:    mul_a = mag_z;
      default: mul_a = {1'b0, threshold};
    endcase
  end

  // shared compare-subtract for square root and divide
  always_comb begin
    case (state)
      ST_SQRT: begin
        sub_a = {rem, sq_n[31:30]};
        sub_b = {1'b0, root, 2'b01};
      end
      ST_DIV: begin
        sub_a = {2'b00, rem[15:0], root[15]};
        sub_b = {3'b000, divisor};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    take = ~diff[19];
  end

  always_comb begin
    if (mag_z > mag_x && mag_z > mag_y) begin
      zone_next = z_neg ? ZONE_Z_NEG : ZONE_Z_POS;
    end else if (mag_x > mag_y) begin
      zone_next = ZONE_X;
    end else begin
      zone_next = ZONE_Y;
    end
    delta = now_q - last_strike[zone_next];
    vel_clip = (root > {9'd0, vel_max}) ? vel_max : root[VelW-1:0];
    vel = (vel_clip < vel_min) ? vel_min : vel_clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      cooldown  <= COOLDOWN_RST;
      divisor   <= DIVISOR_RST;
      vel_min   <= VEL_MIN_RST;
      vel_max   <= VEL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_COOLDOWN:  cooldown  <= cfg_data;
        REG_DIVISOR:   divisor   <= cfg_data;
        REG_VEL_MIN:   vel_min   <= cfg_data[VelW-1:0];
        REG_VEL_MAX:   vel_max   <= cfg_data[VelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      hit_valid <= 1'b0;
      for (int i = 0; i < NumZones; i++) begin
        last_strike[i] <= '0;
      end
    end else begin
      if (hit_valid && hit_ready && state != ST_FIN) begin
        hit_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            mag_x <= sample.accel_x[AccelW-1] ?
                     17'd0 - {sample.accel_x[AccelW-1], sample.accel_x} :
                     {1'b0, sample.accel_x};
            mag_y <= sample.accel_y[AccelW-1] ?
                     17'd0 - {sample.accel_y[AccelW-1], sample.accel_y} :
                     {1'b0, sample.accel_y};
            mag_z <= sample.accel_z[AccelW-1] ?
                     17'd0 - {sample.accel_z[AccelW-1], sample.accel_z} :
                     {1'b0, sample.accel_z};
            z_neg <= sample.accel_z[AccelW-1];
            now_q <= sample.now_ms;
            sum   <= '0;
            cnt   <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt != 4'd4) begin
            prod <= mul_a * mul_a;
          end
          if (cnt != 4'd0 && cnt != 4'd4) begin
            sum <= sum + prod[31:0];
          end
          if (cnt == 4'd4) begin
            thr2  <= prod[31:0];
            state <= ST_CHECK;
          end
          cnt <= cnt + 4'd1;
        end
        ST_CHECK: begin
          if (sum > thr2 && delta > {16'd0, cooldown}) begin
            zone_q <= zone_next;
            sq_n   <= sum;
            rem    <= '0;
            root   <= '0;
            cnt    <= 4'd15;
            state  <= ST_SQRT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SQRT: begin
          root <= {root[14:0], take};
          sq_n <= {sq_n[29:0], 2'b00};
          if (cnt == 4'd0) begin
            rem   <= '0;
            cnt   <= 4'd15;
            state <= ST_DIV;
          end else begin
            rem <= take ? diff[16:0] : sub_a[16:0];
            cnt <= cnt - 4'd1;
          end
        end
        ST_DIV: begin
          // a zero divisor always subtracts, giving an all-ones quotient
          rem  <= take ? diff[16:0] : sub_a[16:0];
          root <= {root[14:0], take};
          cnt  <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!hit_valid || hit_ready) begin
            hit.zone            <= zone_q;
            hit.strength        <= vel;
            hit.hit_time_ms     <= now_q;
            hit_valid           <= 1'b1;
            last_strike[zone_q] <= now_q;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ISC_ASSERT_IMPLY(a_hit_time_logged, hit_valid, last_strike[hit.zone] == hit.hit_time_ms)
  `ISC_ASSERT_IMPLY(a_hit_from_fin, $rose(hit_valid), $past(state == ST_FIN))
  `ISC_ASSERT_NEXT(a_sqrt_to_div, state == ST_SQRT, state == ST_SQRT || state == ST_DIV)

endmodule
